// ===== hdl/u8dw_pkg.sv =====
// Shared types, constants and helper functions for the UTF-8 display width summer.
// No dependencies; used by u8dw_width, utf8_display_width_summer, u8dw_checker and the testbench.
`default_nettype none

package u8dw_pkg;

    // Width of the running column total.
    localparam int WIDTH_BITS = 16;

    // A code point decoded from up to four bytes needs 21 bits.
    localparam int CP_BITS  = 21;
    localparam int NUM_WIDE = 14;

    // Inclusive East Asian wide ranges.
    localparam logic [CP_BITS-1:0] WIDE_LO [NUM_WIDE] = '{
        21'h01100, 21'h02329, 21'h02E80, 21'h03040, 21'h03400, 21'h04E00, 21'h0A000,
        21'h0AC00, 21'h0F900, 21'h0FE10, 21'h0FF01, 21'h0FFE0, 21'h20000, 21'h02329
    };
    localparam logic [CP_BITS-1:0] WIDE_HI [NUM_WIDE] = '{
        21'h0115F, 21'h0232A, 21'h0303E, 21'h033BF, 21'h04DBF, 21'h09FFF, 21'h0A4CF,
        21'h0D7AF, 21'h0FAFF, 21'h0FE6F, 21'h0FF60, 21'h0FFE6, 21'h2FA1F, 21'h0232A
    };

    // Bytes of a pending multi-byte sequence (the final byte is never stored).
    typedef struct packed {
        logic [2:0][7:0] bytes;
        logic [1:0]      count;
        logic [2:0]      need;
    } held_t;

    // Sequence length announced by a lead byte; 1 for ASCII, stray and invalid bytes.
    function automatic logic [2:0] seq_len(input logic [7:0] c);
        logic [2:0] len;
        len = 3'd1;
        if (c[7] == 1'b0)
            len = 3'd1;
        else if (c[7:5] == 3'b110)
            len = 3'd2;
        else if (c[7:4] == 4'b1110)
            len = 3'd3;
        else if (c[7:3] == 5'b11110)
            len = 3'd4;
        return len;
    endfunction

    function automatic logic cp_is_wide(input logic [CP_BITS-1:0] cp);
        logic hit;
        hit = 1'b0;
        for (int i = 0; i < NUM_WIDE; i++)
        begin
            if (cp >= WIDE_LO[i] && cp <= WIDE_HI[i])
                hit = 1'b1;
        end
        return hit;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/utf8_display_width_summer.sv =====
// The result of a range is registered, in the skid register while the output register is full.
// Throughput: one byte per cycle while skid is empty; the total updates in the transfer's cycle.
// An output register plus one skid register keeps input open while a result waits.
// Reset (rst_n low, asynchronous) clears the pending sequence, total and output valids.
// Top level of the UTF-8 display width summer; depends on u8dw_pkg and u8dw_width.
`default_nettype none

module utf8_display_width_summer (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic [7:0]                      data_byte,
    input  wire logic                            has_byte,
    input  wire logic                            last,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic [u8dw_pkg::WIDTH_BITS-1:0]      total_width,
    output logic                                 width_saturated
);

    localparam int W = u8dw_pkg::WIDTH_BITS;

    u8dw_pkg::held_t held_reg, held_next;
    logic [W-1:0]    run_reg, run_next;
    logic            sat_reg, sat_next;

    logic            out_valid_reg, out_valid_next;
    logic [W-1:0]    out_total_reg, out_total_next;
    logic            out_sat_reg, out_sat_next;
    logic            skid_valid_reg, skid_valid_next;
    logic [W-1:0]    skid_total_reg, skid_total_next;
    logic            skid_sat_reg, skid_sat_next;

    logic [1:0]      cols;
    logic [2:0]      lead_len;
    logic            complete;
    logic [1:0]      byte_add;
    logic [1:0]      scan_add;
    logic [2:0]      add;
    logic [W:0]      sum;
    logic [W-1:0]    run_sum;
    logic            sat_sum;
    logic            accept;
    logic            push;
    logic            pop;
    u8dw_pkg::held_t held_upd;

    u8dw_width u_width (
        .held      (held_reg),
        .data_byte (data_byte),
        .cols      (cols)
    );

    assign in_ready = !skid_valid_reg;
    assign accept   = in_valid && in_ready;
    assign push     = accept && last;
    assign pop      = out_valid_reg && out_ready;

    assign out_valid       = out_valid_reg;
    assign total_width     = out_total_reg;
    assign width_saturated = out_sat_reg;

    // Byte handling, end-of-range rescan and saturating add
    always_comb
    begin
        lead_len = u8dw_pkg::seq_len(data_byte);
        complete = (held_reg.count != 2'd0) &&
                   (({1'b0, held_reg.count} + 3'd1) >= held_reg.need);
        held_upd = held_reg;
        byte_add = 2'd0;
        if (has_byte)
        begin
            if (held_reg.count == 2'd0)
            begin
                if (lead_len == 3'd1)
                    byte_add = 2'd1;
                else
                begin
                    held_upd.bytes[0] = data_byte;
                    held_upd.count    = 2'd1;
                    held_upd.need     = lead_len;
                end
            end
            else if (complete)
            begin
                byte_add       = cols;
                held_upd.count = 2'd0;
                held_upd.need  = 3'd0;
            end
            else
            begin
                for (int i = 0; i < 3; i++)
                begin
                    if (held_reg.count == 2'(i))
                        held_upd.bytes[i] = data_byte;
                end
                held_upd.count = held_reg.count + 2'd1;
            end
        end
        // An unfinished sequence at the end counts one column per held byte, except that
        // a two-byte lead in the second slot decodes with the byte behind it (never wide).
        if (!last)
            scan_add = 2'd0;
        else if (held_upd.count == 2'd3 && held_upd.bytes[1][7:5] == 3'b110)
            scan_add = 2'd2;
        else
            scan_add = held_upd.count;
        add      = {1'b0, byte_add} + {1'b0, scan_add};
        sum      = {1'b0, run_reg} + (W+1)'(add);
        run_sum  = sum[W] ? {W{1'b1}} : sum[W-1:0];
        sat_sum  = sat_reg | sum[W];

        held_next = held_reg;
        run_next  = run_reg;
        sat_next  = sat_reg;
        if (accept)
        begin
            if (last)
            begin
                held_next.count = 2'd0;
                held_next.need  = 3'd0;
                run_next        = '0;
                sat_next        = 1'b0;
            end
            else
            begin
                held_next = held_upd;
                run_next  = run_sum;
                sat_next  = sat_sum;
            end
        end
    end

    // Output register with skid stage
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_total_next  = out_total_reg;
        out_sat_next    = out_sat_reg;
        skid_valid_next = skid_valid_reg;
        skid_total_next = skid_total_reg;
        skid_sat_next   = skid_sat_reg;
        if (pop)
        begin
            if (skid_valid_reg)
            begin
                out_total_next  = skid_total_reg;
                out_sat_next    = skid_sat_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = push;
                out_total_next = run_sum;
                out_sat_next   = sat_sum;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_total_next = run_sum;
                out_sat_next   = sat_sum;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_total_next = run_sum;
                skid_sat_next   = sat_sum;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg       <= '0;
            run_reg        <= '0;
            sat_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            held_reg       <= held_next;
            run_reg        <= run_next;
            sat_reg        <= sat_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Payload: no reset needed
    always_ff @(posedge clk)
    begin
        out_total_reg  <= out_total_next;
        out_sat_reg    <= out_sat_next;
        skid_total_reg <= skid_total_next;
        skid_sat_reg   <= skid_sat_next;
    end

endmodule

`default_nettype wire

// ===== hdl/u8dw_width.sv =====
// Decodes the sequence completed by the current byte and gives its column count.
// Depends on u8dw_pkg.
`default_nettype none

module u8dw_width (
    input  wire u8dw_pkg::held_t held,
    input  wire logic [7:0]      data_byte,
    output logic [1:0]           cols
);

    logic [u8dw_pkg::CP_BITS-1:0] cp;

    always_comb
    begin
        unique case (held.need)
            3'd3:
                cp = {5'b0, held.bytes[0][3:0], held.bytes[1][5:0], data_byte[5:0]};
            3'd4:
                cp = {held.bytes[0][2:0], held.bytes[1][5:0], held.bytes[2][5:0],
                      data_byte[5:0]};
            default:
                cp = {10'b0, held.bytes[0][4:0], data_byte[5:0]};
        endcase
        cols = u8dw_pkg::cp_is_wide(cp) ? 2'd2 : 2'd1;
    end

endmodule

`default_nettype wire

// ===== hdl/u8dw_checker.sv =====
// Port-level checks for utf8_display_width_summer, attached with bind.
// Depends on u8dw_pkg.
`default_nettype none

module u8dw_checker (
    input wire logic                            clk,
    input wire logic                            rst_n,
    input wire logic                            in_valid,
    input wire logic                            in_ready,
    input wire logic                            out_valid,
    input wire logic                            out_ready,
    input wire logic [u8dw_pkg::WIDTH_BITS-1:0] total_width,
    input wire logic                            width_saturated
);

    // Hold a stalled result.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(total_width) &&
                                    $stable(width_saturated))
        else $error("stalled result dropped or changed");

    // A clamped total sits at full scale.
    a_sat_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && width_saturated |-> total_width == {u8dw_pkg::WIDTH_BITS{1'b1}})
        else $error("saturated flag without full-scale total");

    // With no result pending, input is open.
    a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input blocked with empty output");

    // Once the output drains, the skid stage is free again.
    a_ready_after_pop: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !in_ready |=> in_ready)
        else $error("input still blocked after result transfer");

endmodule

bind utf8_display_width_summer u8dw_checker u_u8dw_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .total_width     (total_width),
    .width_saturated (width_saturated)
);

`default_nettype wire

// ===== dv/display_width_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for utf8_display_width_summer: watches the byte and result transfers,
// predicts the column total of every range and compares it with the block's result.
// Depends on u8dw_pkg for the width of the total.
module display_width_checker (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    input  wire logic                            in_ready,
    input  wire logic [7:0]                      data_byte,
    input  wire logic                            has_byte,
    input  wire logic                            last,
    input  wire logic                            out_valid,
    input  wire logic                            out_ready,
    input  wire logic [u8dw_pkg::WIDTH_BITS-1:0] total_width,
    input  wire logic                            width_saturated,
    output int                                   mismatches,
    output int                                   widths_owed
);

    localparam longint unsigned COL_MAX = (64'd1 << u8dw_pkg::WIDTH_BITS) - 1;

    typedef struct packed {
        logic [u8dw_pkg::WIDTH_BITS-1:0] cols;
        logic                            clamped;
    } width_result_t;

    // Only entries 0..3 hold bytes; the rest pad the decode window of the tail rescan.
    logic [7:0]      seq_bytes [8];
    int unsigned     seq_have;
    int unsigned     seq_need;
    longint unsigned col_sum;
    logic            col_clamped;
    width_result_t   owed_q [$];
    int              fail_cnt = 0;

    function automatic int unsigned lead_length(input logic [7:0] b);
        casez (b)
            8'b0???????: return 1;
            8'b110?????: return 2;
            8'b1110????: return 3;
            8'b11110???: return 4;
            default:     return 1;
        endcase
    endfunction

    // Continuation bytes contribute their low six bits whatever their top bits are.
    function automatic logic [20:0] code_point(input logic [7:0] b0, input logic [7:0] b1,
                                               input logic [7:0] b2, input logic [7:0] b3,
                                               input int unsigned n);
        case (n)
            2:       return {10'd0, b0[4:0], b1[5:0]};
            3:       return {5'd0, b0[3:0], b1[5:0], b2[5:0]};
            4:       return {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
            default: return {13'd0, b0};
        endcase
    endfunction

    function automatic int unsigned columns_of(input logic [20:0] cp);
        if ((cp >= 21'h01100 && cp <= 21'h0115F) || cp == 21'h02329 || cp == 21'h0232A ||
            (cp >= 21'h02E80 && cp <= 21'h0303E) || (cp >= 21'h03040 && cp <= 21'h033BF) ||
            (cp >= 21'h03400 && cp <= 21'h04DBF) || (cp >= 21'h04E00 && cp <= 21'h09FFF) ||
            (cp >= 21'h0A000 && cp <= 21'h0A4CF) || (cp >= 21'h0AC00 && cp <= 21'h0D7AF) ||
            (cp >= 21'h0F900 && cp <= 21'h0FAFF) || (cp >= 21'h0FE10 && cp <= 21'h0FE6F) ||
            (cp >= 21'h0FF01 && cp <= 21'h0FF60) || (cp >= 21'h0FFE0 && cp <= 21'h0FFE6) ||
            (cp >= 21'h20000 && cp <= 21'h2FA1F))
            return 2;
        return 1;
    endfunction

    // Range cut inside a sequence: a lead with enough bytes behind it decodes,
    // anything else counts one column and the scan moves by one byte.
    function automatic int unsigned rescan_tail();
        int unsigned i;
        int unsigned len;
        int unsigned cols;
        i = 0;
        cols = 0;
        while (i < seq_have)
        begin
            len = lead_length(seq_bytes[i]);
            if (len > 1 && i + len <= seq_have)
            begin
                cols += columns_of(code_point(seq_bytes[i], seq_bytes[i + 1],
                                              seq_bytes[i + 2], seq_bytes[i + 3], len));
                i += len;
            end
            else
            begin
                cols += 1;
                i += 1;
            end
        end
        return cols;
    endfunction

    task automatic add_cols(input int unsigned cols);
        col_sum = col_sum + cols;
        if (col_sum > COL_MAX)
        begin
            col_sum = COL_MAX;
            col_clamped = 1'b1;
        end
    endtask

    task automatic clear_range();
        foreach (seq_bytes[k])
            seq_bytes[k] = 8'h00;
        seq_have = 0;
        seq_need = 0;
        col_sum = 0;
        col_clamped = 1'b0;
    endtask

    task automatic absorb_byte(input logic [7:0] b, input logic hb, input logic lst);
        int unsigned   len;
        width_result_t res;
        if (hb)
        begin
            if (seq_have == 0)
            begin
                len = lead_length(b);
                if (len == 1)
                    add_cols(1);
                else
                begin
                    seq_bytes[0] = b;
                    seq_have = 1;
                    seq_need = len;
                end
            end
            else
            begin
                if (seq_have < 4)
                begin
                    seq_bytes[seq_have] = b;
                    seq_have++;
                end
                if (seq_have >= seq_need)
                begin
                    add_cols(columns_of(code_point(seq_bytes[0], seq_bytes[1],
                                                   seq_bytes[2], seq_bytes[3], seq_need)));
                    foreach (seq_bytes[k])
                        seq_bytes[k] = 8'h00;
                    seq_have = 0;
                    seq_need = 0;
                end
            end
        end
        if (lst)
        begin
            if (seq_have != 0)
                add_cols(rescan_tail());
            res.cols = col_sum[u8dw_pkg::WIDTH_BITS-1:0];
            res.clamped = col_clamped;
            owed_q.push_back(res);
            clear_range();
        end
    endtask

    task automatic note_failure(input string msg);
        if (fail_cnt < 10)
            $display("%0t ns: %s", $time, msg);
        fail_cnt++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        width_result_t exp_res;
        if (!rst_n)
        begin
            clear_range();
            owed_q.delete();
        end
        else
        begin
            // Compare the result first: a range closed on this edge is not visible yet.
            if (out_valid && out_ready)
            begin
                if (owed_q.size() == 0)
                    note_failure($sformatf("unexpected result total_width=%0d saturated=%b",
                                           total_width, width_saturated));
                else
                begin
                    exp_res = owed_q.pop_front();
                    if (total_width !== exp_res.cols || width_saturated !== exp_res.clamped)
                        note_failure($sformatf(
                            "total_width exp %0d got %0d, saturated exp %b got %b",
                            exp_res.cols, total_width, exp_res.clamped, width_saturated));
                end
            end
            if (in_valid && in_ready)
                absorb_byte(data_byte, has_byte, last);
        end
        mismatches <= fail_cnt;
        widths_owed <= owed_q.size();
    end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// Top of the utf8_display_width_summer testbench: drives byte ranges under several
// idling patterns and gives the verdict; prediction lives in display_width_checker.
module tb;

    localparam int HOLD_CYCLES  = 300;
    localparam int PHASE_ITEMS  = 375;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 1000000;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            in_valid = 1'b0;
    logic [7:0]                      data_byte = 8'h00;
    logic                            has_byte = 1'b0;
    logic                            last = 1'b0;
    logic                            out_ready = 1'b0;
    logic                            in_ready;
    logic                            out_valid;
    logic [u8dw_pkg::WIDTH_BITS-1:0] total_width;
    logic                            width_saturated;
    int                              mismatches;
    int                              widths_owed;

    int         send_idle_pct = 0;
    int         recv_stall_pct = 0;
    int         hold_requests = 0;
    int         hold_taken = 0;
    int         hold_left = 0;
    int         range_items = 0;
    int         cycle_cnt = 0;
    logic [7:0] range_bytes [$];

    always #1 clk = ~clk;

    utf8_display_width_summer u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .data_byte       (data_byte),
        .has_byte        (has_byte),
        .last            (last),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .total_width     (total_width),
        .width_saturated (width_saturated)
    );

    display_width_checker u_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .data_byte       (data_byte),
        .has_byte        (has_byte),
        .last            (last),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .total_width     (total_width),
        .width_saturated (width_saturated),
        .mismatches      (mismatches),
        .widths_owed     (widths_owed)
    );

    // Receiver: a new hold request starts a long stall, otherwise stall at random.
    always @(posedge clk)
    begin
        if (hold_taken != hold_requests)
        begin
            hold_taken <= hold_requests;
            hold_left <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Returns at the edge where the byte transfer took place.
    task automatic offer_byte(input logic [7:0] b, input logic hb, input logic lst);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        data_byte <= b;
        has_byte <= hb;
        last <= lst;
        if (hb || lst)
            range_items++;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic await_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (widths_owed != 0)
            @(posedge clk);
    endtask

    // Encode with n bytes; now and then corrupt the tag bits of a continuation byte.
    task automatic push_code_point(input logic [20:0] cp, input int n);
        logic [1:0] tag;
        case (n)
            2:       range_bytes.push_back({3'b110, cp[10:6]});
            3:       range_bytes.push_back({4'b1110, cp[15:12]});
            default: range_bytes.push_back({5'b11110, cp[20:18]});
        endcase
        for (int k = n - 2; k >= 0; k--)
        begin
            tag = 2'b10;
            if ($urandom_range(9) == 0)
                tag = 2'($urandom_range(3));
            range_bytes.push_back({tag, cp[6*k +: 6]});
        end
    endtask

    task automatic push_random_char();
        int unsigned pick;
        int          n;
        logic [20:0] lo;
        logic [20:0] hi;
        logic [20:0] cp;
        pick = $urandom_range(99);
        if (pick < 25)
            range_bytes.push_back(8'($urandom_range(127)));
        else if (pick < 45)
        begin
            // Edges of the wide ranges, and one step outside them.
            case ($urandom_range(13))
                0:       begin lo = 21'h01100; hi = 21'h0115F; end
                1:       begin lo = 21'h02329; hi = 21'h02329; end
                2:       begin lo = 21'h0232A; hi = 21'h0232A; end
                3:       begin lo = 21'h02E80; hi = 21'h0303E; end
                4:       begin lo = 21'h03040; hi = 21'h033BF; end
                5:       begin lo = 21'h03400; hi = 21'h04DBF; end
                6:       begin lo = 21'h04E00; hi = 21'h09FFF; end
                7:       begin lo = 21'h0A000; hi = 21'h0A4CF; end
                8:       begin lo = 21'h0AC00; hi = 21'h0D7AF; end
                9:       begin lo = 21'h0F900; hi = 21'h0FAFF; end
                10:      begin lo = 21'h0FE10; hi = 21'h0FE6F; end
                11:      begin lo = 21'h0FF01; hi = 21'h0FF60; end
                12:      begin lo = 21'h0FFE0; hi = 21'h0FFE6; end
                default: begin lo = 21'h20000; hi = 21'h2FA1F; end
            endcase
            case ($urandom_range(3))
                0:       cp = lo - 21'd1;
                1:       cp = lo;
                2:       cp = hi;
                default: cp = hi + 21'd1;
            endcase
            push_code_point(cp, (cp > 21'h0FFFF) ? 4 : 3);
        end
        else if (pick < 55)
            push_code_point(21'($urandom_range(12'h7FF, 8'h80)), 2);
        else if (pick < 68)
            push_code_point(21'($urandom_range(16'hFFFF)), 3);
        else if (pick < 75)
            push_code_point(21'($urandom_range(21'h1FFFFF)), 4);
        else if (pick < 80)
            push_code_point(21'($urandom_range(21'h30000, 21'h1F000)), 4);
        else if (pick < 87)
        begin
            if ($urandom_range(1) == 0)
                range_bytes.push_back(8'($urandom_range(8'hBF, 8'h80)));
            else
                range_bytes.push_back(8'($urandom_range(8'hFF, 8'hF8)));
        end
        else if (pick < 94)
        begin
            // Cut a sequence short; what follows is absorbed into it.
            n = $urandom_range(4, 2);
            push_code_point(21'($urandom_range(21'h1FFFFF)), n);
            repeat ($urandom_range(n - 1, 1))
                void'(range_bytes.pop_back());
        end
        else
            range_bytes.push_back(8'($urandom_range(255)));
    endtask

    task automatic send_random_range();
        int unsigned nchars;
        bit          close_on_byte;
        range_bytes.delete();
        nchars = ($urandom_range(19) == 0) ? 0 : $urandom_range(10, 1);
        close_on_byte = ($urandom_range(4) != 0);
        repeat (nchars)
            push_random_char();
        foreach (range_bytes[i])
        begin
            if ($urandom_range(19) == 0)
                offer_byte(8'($urandom_range(255)), 1'b0, 1'b0);
            offer_byte(range_bytes[i], 1'b1,
                       close_on_byte && (i == range_bytes.size() - 1));
        end
        if (!close_on_byte || range_bytes.size() == 0)
            offer_byte(8'($urandom_range(255)), 1'b0, 1'b1);
    endtask

    initial
    begin
        while (cycle_cnt < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("utf8_display_width_summer verification failed");
        $finish;
    end

    initial
    begin
        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty range, ignored step, ASCII extremes.
        offer_byte(8'h5A, 1'b0, 1'b1);
        offer_byte(8'hA5, 1'b0, 1'b0);
        offer_byte(8'h00, 1'b1, 1'b0);
        offer_byte(8'h7F, 1'b1, 1'b1);
        // Stray continuations and invalid leads.
        offer_byte(8'h80, 1'b1, 1'b0);
        offer_byte(8'hBF, 1'b1, 1'b0);
        offer_byte(8'hF8, 1'b1, 1'b0);
        offer_byte(8'hFF, 1'b1, 1'b1);
        // Two, three and four byte sequences, narrow and wide.
        offer_byte(8'hC3, 1'b1, 1'b0);
        offer_byte(8'hA9, 1'b1, 1'b0);
        offer_byte(8'hE1, 1'b1, 1'b0);
        offer_byte(8'h84, 1'b1, 1'b0);
        offer_byte(8'h80, 1'b1, 1'b1);
        offer_byte(8'hF0, 1'b1, 1'b0);
        offer_byte(8'hA0, 1'b1, 1'b0);
        offer_byte(8'h80, 1'b1, 1'b0);
        offer_byte(8'h80, 1'b1, 1'b1);
        // Ranges that end inside a sequence.
        offer_byte(8'hE4, 1'b1, 1'b0);
        offer_byte(8'hB8, 1'b1, 1'b1);
        offer_byte(8'hF0, 1'b1, 1'b0);
        offer_byte(8'hC3, 1'b1, 1'b0);
        offer_byte(8'hA9, 1'b1, 1'b1);
        offer_byte(8'hE4, 1'b1, 1'b0);
        offer_byte(8'h00, 1'b0, 1'b1);
        await_results();

        // Long receiver hold while single-byte ranges pile up behind it.
        hold_requests <= hold_requests + 1;
        repeat (40)
            offer_byte(8'($urandom_range(255)), 1'b1, 1'b1);
        await_results();

        for (int p = 0; p < 4; p++)
        begin
            case (p)
                0:       begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
                1:       begin send_idle_pct = 49; recv_stall_pct <= 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct <= 49; end
                default: begin send_idle_pct = 32; recv_stall_pct <= 32; end
            endcase
            range_items = 0;
            while (range_items < PHASE_ITEMS)
                send_random_range();
            await_results();
        end

        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (mismatches == 0 && widths_owed == 0)
            $display("utf8_display_width_summer verification clean");
        else
            $display("utf8_display_width_summer verification failed");
        $finish;
    end

endmodule
